// ===== hdl/gcr_pkg.sv =====
// ----------------------------------------------------------------------------
// gcr_pkg: grid ray caster shared types and constants
// Field widths, fixed-point scales, controller states and control structs.
// ----------------------------------------------------------------------------
package gcr_pkg;

	localparam int TILE_PX    = 64;
	localparam int MAP_COLS   = 32;
	localparam int MAP_ROWS   = 32;
	localparam int ANGLE_BITS = 12;
	localparam int FRAC_BITS  = 8;

	localparam int ROW_W   = 5;
	localparam int COL_W   = 5;
	localparam int CELL_W  = 4;
	localparam int POS_W   = 19;
	localparam int STRIP_W = 10;
	localparam int DIST_W  = 20;
	localparam int CELLS   = MAP_ROWS * MAP_COLS;
	localparam int ADDR_W  = $clog2(CELLS);

	localparam int TILE_SH = $clog2(TILE_PX) + FRAC_BITS;
	localparam int TILE_FX = 1 << TILE_SH;
	localparam int PIX_FX  = 1 << FRAC_BITS;

	// CORDIC
	localparam int CRD_W     = 18;
	localparam int CRD_ITERS = 14;
	localparam int CRD_X0    = 9949;
	localparam int MAG_W     = CRD_W - 1;

	// Q16 ratio divider
	localparam int Q_SH      = 16;
	localparam int DIV_STEPS = MAG_W + Q_SH;
	localparam int RAT_W     = DIV_STEPS + 1;
	localparam logic [RAT_W-1:0] RAT_SAT = RAT_W'(1) << (RAT_W - 1);

	// offset multiply, split in two partial products
	localparam int D_W   = TILE_SH + 1;
	localparam int Q_LO  = 17;
	localparam int ACC_W = D_W + RAT_W;

	// march coordinates
	localparam int PT_W = 36;
	localparam logic signed [PT_W-1:0] W_PT    = PT_W'(MAP_COLS * TILE_FX);
	localparam logic signed [PT_W-1:0] H_PT    = PT_W'(MAP_ROWS * TILE_FX);
	localparam logic signed [PT_W-1:0] TILE_PT = PT_W'(TILE_FX);
	localparam logic signed [PT_W-1:0] PIX_PT  = PT_W'(PIX_FX);
	localparam logic signed [PT_W-1:0] POS_MAX = PT_W'((1 << POS_W) - 1);

	// distance
	localparam int DX_W       = POS_W + 1;
	localparam int SQ_W       = 2 * DX_W + 1;
	localparam int SQRT_STEPS = DX_W;
	localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(1) << (2 * (SQRT_STEPS - 1));
	localparam int DST_W      = DX_W + 1;
	localparam logic [DST_W-1:0] DST_NONE = '1;
	localparam logic [DST_W-1:0] DST_MAX  = DST_W'((1 << DIST_W) - 1);

	localparam logic [ANGLE_BITS-1:0] ANG_HALF = ANGLE_BITS'(1 << (ANGLE_BITS - 1));
	localparam logic [ANGLE_BITS-1:0] ANG_QTR  = ANGLE_BITS'(1 << (ANGLE_BITS - 2));
	localparam logic [ANGLE_BITS-1:0] ANG_3QTR = ANGLE_BITS'(3 << (ANGLE_BITS - 2));

	localparam int CNT_W = ADDR_W + 1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CORDIC,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_STORE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MARCH_INIT,
		ST_MARCH_ADDR,
		ST_MARCH_CHECK,
		ST_SQ_LO,
		ST_SQ_HI,
		ST_SQRT,
		ST_DIST_STORE,
		ST_FINISH
	} gcr_state_t;

	typedef struct packed {
		logic             load;
		logic             cell_wr;
		logic             clear;
		logic             crd_step;
		logic             div_init;
		logic             div_step;
		logic             div_store;
		logic             mul_lo;
		logic             mul_hi;
		logic             march_init;
		logic             march_addr;
		logic             march_check;
		logic             sq_lo;
		logic             sq_hi;
		logic             sqrt_step;
		logic             dist_store;
		logic             finish;
		logic             sel;
		logic [CNT_W-1:0] cnt;
	} gcr_cmd_t;

	typedef struct packed {
		logic in_map;
		logic hit;
	} gcr_stat_t;

	function automatic logic signed [CRD_W-1:0] crd_atan(input logic [3:0] i);
		logic signed [CRD_W-1:0] v;
		case (i)
			4'd0:    v = 18'sd8192;
			4'd1:    v = 18'sd4836;
			4'd2:    v = 18'sd2555;
			4'd3:    v = 18'sd1297;
			4'd4:    v = 18'sd651;
			4'd5:    v = 18'sd326;
			4'd6:    v = 18'sd163;
			4'd7:    v = 18'sd81;
			4'd8:    v = 18'sd41;
			4'd9:    v = 18'sd20;
			4'd10:   v = 18'sd10;
			4'd11:   v = 18'sd5;
			4'd12:   v = 18'sd3;
			4'd13:   v = 18'sd1;
			default: v = 18'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/grid_ray_caster_top.sv =====
// ----------------------------------------------------------------------------
// grid_ray_caster_top: tile map ray caster
// Casts one ray over a 32x32 tile map and reports the nearest wall hit.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. cmd selects a map
//   cell write (cell_row, cell_col, cell_value) or a ray cast (viewer_x,
//   viewer_y, ray_dir, strip_number).
//   A cell write gives no result; busy stays low.
//   A cast raises busy and gives one result, shown for exactly one cycle
//   with done high; the receiver cannot stall it.
//   A cast runs the 14-step CORDIC, two 33-step bit-serial divides, the two
//   marches (RAM read and check per grid line) and two 20-step square roots.
//   A new item can be taken in the cycle in which done is high.
//   Reset: the tile map is cleared by a pass over all 1024 cells, one cell
//   per cycle, with busy high; after that the block is idle.
// ----------------------------------------------------------------------------
module grid_ray_caster_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           cmd,
	input  logic [gcr_pkg::ROW_W-1:0]      cell_row,
	input  logic [gcr_pkg::COL_W-1:0]      cell_col,
	input  logic [gcr_pkg::CELL_W-1:0]     cell_value,
	input  logic [gcr_pkg::POS_W-1:0]      viewer_x,
	input  logic [gcr_pkg::POS_W-1:0]      viewer_y,
	input  logic [gcr_pkg::ANGLE_BITS-1:0] ray_dir,
	input  logic [gcr_pkg::STRIP_W-1:0]    strip_number,
	output logic                           done,
	output logic [gcr_pkg::STRIP_W-1:0]    strip_out,
	output logic [gcr_pkg::DIST_W-1:0]     hit_distance,
	output logic [gcr_pkg::POS_W-1:0]      hit_x,
	output logic [gcr_pkg::POS_W-1:0]      hit_y,
	output logic [gcr_pkg::CELL_W-1:0]     hit_content,
	output logic                           hit_on_vertical,
	output logic                           hit_found,
	output logic [gcr_pkg::ANGLE_BITS-1:0] dir_out
);
	import gcr_pkg::*;

	gcr_cmd_t  ctl;
	gcr_stat_t stat;

	gcr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd_in (cmd),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	gcr_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.stat            (stat),
		.cell_row        (cell_row),
		.cell_col        (cell_col),
		.cell_value      (cell_value),
		.viewer_x        (viewer_x),
		.viewer_y        (viewer_y),
		.ray_dir         (ray_dir),
		.strip_number    (strip_number),
		.done            (done),
		.strip_out       (strip_out),
		.hit_distance    (hit_distance),
		.hit_x           (hit_x),
		.hit_y           (hit_y),
		.hit_content     (hit_content),
		.hit_on_vertical (hit_on_vertical),
		.hit_found       (hit_found),
		.dir_out         (dir_out)
	);

endmodule

// ===== hdl/gcr_ram.sv =====
// ----------------------------------------------------------------------------
// gcr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gcr_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

// ===== hdl/gcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcr_ctrl: grid ray caster controller
// Sequences map clear, CORDIC, ratio divides, marches and square roots.
// ----------------------------------------------------------------------------
module gcr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                cmd_in,
	input  gcr_pkg::gcr_stat_t  stat,
	output logic                busy,
	output gcr_pkg::gcr_cmd_t   ctl
);
	import gcr_pkg::*;

	gcr_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             sel_q, sel_d;
	logic             march_exit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		sel_d      = sel_q;
		march_exit = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (cnt_q == CNT_W'(CELLS - 1)) begin
					state_d = ST_IDLE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (start && cmd_in == CMD_CAST) begin
					state_d = ST_CORDIC;
					cnt_d   = '0;
				end
			end
			ST_CORDIC: begin
				if (cnt_q == CNT_W'(CRD_ITERS - 1)) begin
					state_d = ST_DIV_INIT;
					cnt_d   = '0;
					sel_d   = 1'b0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIV_INIT: begin
				state_d = ST_DIV;
				cnt_d   = '0;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_DIV_STORE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIV_STORE: begin
				if (!sel_q) begin
					state_d = ST_DIV_INIT;
					sel_d   = 1'b1;
				end else begin
					state_d = ST_MUL_LO;
					sel_d   = 1'b0;
				end
			end
			ST_MUL_LO:     state_d = ST_MUL_HI;
			ST_MUL_HI:     state_d = ST_MARCH_INIT;
			ST_MARCH_INIT: state_d = ST_MARCH_ADDR;
			ST_MARCH_ADDR: begin
				if (stat.in_map) begin
					state_d = ST_MARCH_CHECK;
				end else begin
					march_exit = 1'b1;
				end
			end
			ST_MARCH_CHECK: begin
				if (stat.hit) begin
					march_exit = 1'b1;
				end else begin
					state_d = ST_MARCH_ADDR;
				end
			end
			ST_SQ_LO: state_d = ST_SQ_HI;
			ST_SQ_HI: begin
				state_d = ST_SQRT;
				cnt_d   = '0;
			end
			ST_SQRT: begin
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
					state_d = ST_DIST_STORE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIST_STORE: begin
				if (!sel_q) begin
					state_d = ST_SQ_LO;
					sel_d   = 1'b1;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
		if (march_exit) begin
			if (!sel_q) begin
				state_d = ST_MUL_LO;
				sel_d   = 1'b1;
			end else begin
				state_d = ST_SQ_LO;
				sel_d   = 1'b0;
			end
		end
	end

	always_comb begin
		ctl     = '0;
		ctl.cnt = cnt_q;
		ctl.sel = sel_q;
		busy    = 1'b1;
		unique case (state_q)
			ST_CLEAR: ctl.clear = 1'b1;
			ST_IDLE: begin
				busy        = 1'b0;
				ctl.load    = start && cmd_in == CMD_CAST;
				ctl.cell_wr = start && cmd_in == CMD_WRITE;
			end
			ST_CORDIC:      ctl.crd_step    = 1'b1;
			ST_DIV_INIT:    ctl.div_init    = 1'b1;
			ST_DIV:         ctl.div_step    = 1'b1;
			ST_DIV_STORE:   ctl.div_store   = 1'b1;
			ST_MUL_LO:      ctl.mul_lo      = 1'b1;
			ST_MUL_HI:      ctl.mul_hi      = 1'b1;
			ST_MARCH_INIT:  ctl.march_init  = 1'b1;
			ST_MARCH_ADDR:  ctl.march_addr  = 1'b1;
			ST_MARCH_CHECK: ctl.march_check = 1'b1;
			ST_SQ_LO:       ctl.sq_lo       = 1'b1;
			ST_SQ_HI:       ctl.sq_hi       = 1'b1;
			ST_SQRT:        ctl.sqrt_step   = 1'b1;
			ST_DIST_STORE:  ctl.dist_store  = 1'b1;
			ST_FINISH:      ctl.finish      = 1'b1;
			default:        busy            = 1'b1;
		endcase
	end

endmodule

// ===== hdl/gcr_datapath.sv =====
// ----------------------------------------------------------------------------
// gcr_datapath: grid ray caster datapath
// CORDIC, shared bit-serial divider, split offset multiply, grid march over
// the tile RAM, bit-pair square root and result registers.
// ----------------------------------------------------------------------------
module gcr_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  gcr_pkg::gcr_cmd_t                      ctl,
	output gcr_pkg::gcr_stat_t                     stat,
	input  logic [gcr_pkg::ROW_W-1:0]              cell_row,
	input  logic [gcr_pkg::COL_W-1:0]              cell_col,
	input  logic [gcr_pkg::CELL_W-1:0]             cell_value,
	input  logic [gcr_pkg::POS_W-1:0]              viewer_x,
	input  logic [gcr_pkg::POS_W-1:0]              viewer_y,
	input  logic [gcr_pkg::ANGLE_BITS-1:0]         ray_dir,
	input  logic [gcr_pkg::STRIP_W-1:0]            strip_number,
	output logic                                   done,
	output logic [gcr_pkg::STRIP_W-1:0]            strip_out,
	output logic [gcr_pkg::DIST_W-1:0]             hit_distance,
	output logic [gcr_pkg::POS_W-1:0]              hit_x,
	output logic [gcr_pkg::POS_W-1:0]              hit_y,
	output logic [gcr_pkg::CELL_W-1:0]             hit_content,
	output logic                                   hit_on_vertical,
	output logic                                   hit_found,
	output logic [gcr_pkg::ANGLE_BITS-1:0]         dir_out
);
	import gcr_pkg::*;

	// item registers
	logic [POS_W-1:0]      vx_q, vy_q;
	logic [ANGLE_BITS-1:0] dir_q;
	logic [STRIP_W-1:0]    strip_q;
	logic                  down, up, right, left;

	assign down  = (dir_q != '0) && (dir_q < ANG_HALF);
	assign up    = !down;
	assign right = (dir_q < ANG_QTR) || (dir_q > ANG_3QTR);
	assign left  = !right;

	// CORDIC
	logic signed [CRD_W-1:0] cx_q, cy_q, cz_q;
	logic                    flip_q;
	logic [15:0]             ph, ph_f;
	logic                    ph_flip;
	logic [3:0]              it;
	logic signed [CRD_W-1:0] cx_sh, cy_sh;

	assign ph      = {ray_dir, {(16 - ANGLE_BITS){1'b0}}};
	assign ph_flip = ph[15] ^ ph[14];
	assign ph_f    = ph_flip ? (ph ^ 16'h8000) : ph;
	assign it      = ctl.cnt[3:0];
	assign cx_sh   = cx_q >>> it;
	assign cy_sh   = cy_q >>> it;

	// ratio divider
	logic signed [CRD_W-1:0] s_val, c_val, s_abs, c_abs;
	logic [MAG_W-1:0]        s_mag, c_mag, n_mag, d_mag;
	logic [DIV_STEPS-1:0]    num_q;
	logic [MAG_W-1:0]        den_q, rem_q;
	logic [DIV_STEPS-1:0]    quo_q;
	logic                    nz_q, dz_q, rneg_q;
	logic [MAG_W:0]          trial, tdiff;
	logic                    ge;
	logic [RAT_W-1:0]        ratio;
	logic [RAT_W-1:0]        tan_mag_q, cot_mag_q;
	logic                    tan_neg_q, cot_neg_q;

	assign s_val = flip_q ? -cy_q : cy_q;
	assign c_val = flip_q ? -cx_q : cx_q;
	assign s_abs = s_val[CRD_W-1] ? -s_val : s_val;
	assign c_abs = c_val[CRD_W-1] ? -c_val : c_val;
	assign s_mag = s_abs[MAG_W-1:0];
	assign c_mag = c_abs[MAG_W-1:0];
	assign n_mag = ctl.sel ? c_mag : s_mag;
	assign d_mag = ctl.sel ? s_mag : c_mag;
	assign trial = {rem_q, num_q[DIV_STEPS-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign tdiff = trial - {1'b0, den_q};
	assign ratio = nz_q ? '0 : (dz_q ? RAT_SAT : {1'b0, quo_q});

	// offset multiply: horizontal march uses cot, vertical uses tan
	logic [RAT_W-1:0]        q_mag;
	logic                    q_neg;
	logic [TILE_SH-1:0]      fx, fy;
	logic [D_W-1:0]          dmag;
	logic [D_W+Q_LO-1:0]     ml, mh;
	logic [ACC_W-1:0]        acc_q;

	assign q_mag = ctl.sel ? tan_mag_q : cot_mag_q;
	assign q_neg = ctl.sel ? tan_neg_q : cot_neg_q;
	assign fx    = vx_q[TILE_SH-1:0];
	assign fy    = vy_q[TILE_SH-1:0];
	always_comb begin
		if (!ctl.sel) begin
			dmag = down ? D_W'(TILE_FX) - D_W'(fy) : D_W'(fy);
		end else begin
			dmag = right ? D_W'(TILE_FX) - D_W'(fx) : D_W'(fx);
		end
	end
	assign ml = (D_W + Q_LO)'(dmag) * (D_W + Q_LO)'(q_mag[Q_LO-1:0]);
	assign mh = (D_W + Q_LO)'(dmag) * (D_W + Q_LO)'(q_mag[RAT_W-1:Q_LO]);

	// march
	logic signed [PT_W-1:0]       offs, off_ext, stp, base_x, base_y;
	logic [RAT_W+TILE_SH-1:0]     stp_wide;
	logic                         off_neg;
	logic signed [PT_W-1:0]       px_q, py_q, sx_q, sy_q;
	logic                         mode_v_q, chk_ok_q;
	logic signed [PT_W-1:0]       chx, chy;
	logic                         cell_ok;
	logic [ADDR_W-1:0]            raddr, waddr;
	logic [CELL_W-1:0]            rdata, wdata;
	logic                         we;

	assign off_ext  = PT_W'(acc_q[ACC_W-1:Q_SH]);
	assign off_neg  = (ctl.sel ? left : up) ^ q_neg;
	assign offs     = off_neg ? -off_ext : off_ext;
	assign stp_wide = {q_mag, {TILE_SH{1'b0}}};
	assign stp      = PT_W'(stp_wide >> Q_SH);
	assign base_x   = PT_W'({vx_q[POS_W-1:TILE_SH], {TILE_SH{1'b0}}})
		+ (right ? TILE_PT : '0);
	assign base_y   = PT_W'({vy_q[POS_W-1:TILE_SH], {TILE_SH{1'b0}}})
		+ (down ? TILE_PT : '0);

	assign chx     = px_q - ((mode_v_q && left) ? PIX_PT : '0);
	assign chy     = py_q - ((!mode_v_q && up) ? PIX_PT : '0);
	assign cell_ok = !chx[PT_W-1] && (chx < W_PT) && !chy[PT_W-1] && (chy < H_PT);
	assign raddr   = {chy[TILE_SH+ROW_W-1:TILE_SH], chx[TILE_SH+COL_W-1:TILE_SH]};

	assign stat.in_map = !px_q[PT_W-1] && (px_q <= W_PT) && !py_q[PT_W-1] && (py_q <= H_PT);
	assign stat.hit    = chk_ok_q && (rdata != '0);

	// rows and columns are full width for the map, so every write lands
	assign we    = ctl.clear || ctl.cell_wr;
	assign waddr = ctl.clear ? ctl.cnt[ADDR_W-1:0] : {cell_row, cell_col};
	assign wdata = ctl.clear ? '0 : cell_value;

	gcr_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_map (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (raddr),
		.rdata_q (rdata)
	);

	// march results
	logic                   h_found_q, v_found_q;
	logic signed [PT_W-1:0] h_x_q, h_y_q, v_x_q, v_y_q;
	logic [CELL_W-1:0]      h_cont_q, v_cont_q;

	// distance
	logic signed [PT_W-1:0] mx, my, dx, dy;
	logic [DX_W-1:0]        adx, ady;
	logic [2*DX_W-1:0]      sqx, sqy;
	logic [SQ_W-1:0]        n_q, res_q, bit_q, tsum;
	logic                   m_found;
	logic [DST_W-1:0]       h_dist_q, v_dist_q, dist_d;

	assign mx      = ctl.sel ? v_x_q : h_x_q;
	assign my      = ctl.sel ? v_y_q : h_y_q;
	assign m_found = ctl.sel ? v_found_q : h_found_q;
	assign dx      = mx - PT_W'(vx_q);
	assign dy      = my - PT_W'(vy_q);
	assign adx     = dx[PT_W-1] ? DX_W'(-dx) : DX_W'(dx);
	assign ady     = dy[PT_W-1] ? DX_W'(-dy) : DX_W'(dy);
	assign sqx     = (2 * DX_W)'(adx) * (2 * DX_W)'(adx);
	assign sqy     = (2 * DX_W)'(ady) * (2 * DX_W)'(ady);
	assign tsum    = res_q + bit_q;
	assign dist_d  = m_found ? res_q[DST_W-1:0] : DST_NONE;

	// final selection
	logic                   use_v;
	logic [DST_W-1:0]       pick_dist;
	logic signed [PT_W-1:0] pick_x, pick_y;
	logic [POS_W-1:0]       clamp_x, clamp_y;

	assign use_v     = v_dist_q < h_dist_q;
	assign pick_dist = use_v ? v_dist_q : h_dist_q;
	assign pick_x    = use_v ? v_x_q : h_x_q;
	assign pick_y    = use_v ? v_y_q : h_y_q;
	assign clamp_x   = pick_x[PT_W-1] ? '0 :
		(pick_x > POS_MAX ? POS_W'(POS_MAX) : pick_x[POS_W-1:0]);
	assign clamp_y   = pick_y[PT_W-1] ? '0 :
		(pick_y > POS_MAX ? POS_W'(POS_MAX) : pick_y[POS_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			vx_q    <= viewer_x;
			vy_q    <= viewer_y;
			dir_q   <= ray_dir;
			strip_q <= strip_number;
			cx_q    <= CRD_W'(CRD_X0);
			cy_q    <= '0;
			cz_q    <= {{(CRD_W - 16){ph_f[15]}}, ph_f};
			flip_q  <= ph_flip;
		end
		if (ctl.crd_step) begin
			if (!cz_q[CRD_W-1]) begin
				cx_q <= cx_q - cy_sh;
				cy_q <= cy_q + cx_sh;
				cz_q <= cz_q - crd_atan(it);
			end else begin
				cx_q <= cx_q + cy_sh;
				cy_q <= cy_q - cx_sh;
				cz_q <= cz_q + crd_atan(it);
			end
		end
		if (ctl.div_init) begin
			num_q  <= {n_mag, {Q_SH{1'b0}}};
			den_q  <= d_mag;
			rem_q  <= '0;
			quo_q  <= '0;
			nz_q   <= n_mag == '0;
			dz_q   <= d_mag == '0;
			rneg_q <= s_val[CRD_W-1] ^ c_val[CRD_W-1];
		end
		if (ctl.div_step) begin
			rem_q <= ge ? tdiff[MAG_W-1:0] : trial[MAG_W-1:0];
			quo_q <= {quo_q[DIV_STEPS-2:0], ge};
			num_q <= num_q << 1;
		end
		if (ctl.div_store) begin
			if (!ctl.sel) begin
				tan_mag_q <= ratio;
				tan_neg_q <= rneg_q;
			end else begin
				cot_mag_q <= ratio;
				cot_neg_q <= rneg_q;
			end
		end
		if (ctl.mul_lo) begin
			acc_q <= ACC_W'(ml);
		end
		if (ctl.mul_hi) begin
			acc_q <= acc_q + (ACC_W'(mh) << Q_LO);
		end
		if (ctl.march_init) begin
			mode_v_q <= ctl.sel;
			if (!ctl.sel) begin
				px_q      <= PT_W'(vx_q) + offs;
				py_q      <= base_y;
				sx_q      <= right ? stp : -stp;
				sy_q      <= up ? -TILE_PT : TILE_PT;
				h_found_q <= 1'b0;
				h_x_q     <= '0;
				h_y_q     <= '0;
				h_cont_q  <= '0;
			end else begin
				px_q      <= base_x;
				py_q      <= PT_W'(vy_q) + offs;
				sx_q      <= left ? -TILE_PT : TILE_PT;
				sy_q      <= up ? -stp : stp;
				v_found_q <= 1'b0;
				v_x_q     <= '0;
				v_y_q     <= '0;
				v_cont_q  <= '0;
			end
		end
		if (ctl.march_addr) begin
			chk_ok_q <= cell_ok;
		end
		if (ctl.march_check) begin
			if (stat.hit) begin
				if (!mode_v_q) begin
					h_found_q <= 1'b1;
					h_x_q     <= px_q;
					h_y_q     <= py_q;
					h_cont_q  <= rdata;
				end else begin
					v_found_q <= 1'b1;
					v_x_q     <= px_q;
					v_y_q     <= py_q;
					v_cont_q  <= rdata;
				end
			end else begin
				px_q <= px_q + sx_q;
				py_q <= py_q + sy_q;
			end
		end
		if (ctl.sq_lo) begin
			n_q   <= SQ_W'(sqx);
			res_q <= '0;
			bit_q <= SQ_BIT0;
		end
		if (ctl.sq_hi) begin
			n_q <= n_q + SQ_W'(sqy);
		end
		if (ctl.sqrt_step) begin
			if (n_q >= tsum) begin
				n_q   <= n_q - tsum;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (ctl.dist_store) begin
			if (!ctl.sel) begin
				h_dist_q <= dist_d;
			end else begin
				v_dist_q <= dist_d;
			end
		end
		if (ctl.finish) begin
			strip_out       <= strip_q;
			hit_distance    <= (pick_dist > DST_MAX) ? DIST_W'(DST_MAX)
				: pick_dist[DIST_W-1:0];
			hit_x           <= clamp_x;
			hit_y           <= clamp_y;
			hit_content     <= use_v ? v_cont_q : h_cont_q;
			hit_on_vertical <= use_v;
			hit_found       <= h_found_q || v_found_q;
			dir_out         <= dir_q;
		end
	end

endmodule

// ===== hdl/gcr_checker.sv =====
// ----------------------------------------------------------------------------
// gcr_checker: port-level checks for the grid ray caster
// Watches the top level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module gcr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           cmd,
	input logic                           done,
	input logic [gcr_pkg::DIST_W-1:0]     hit_distance,
	input logic [gcr_pkg::POS_W-1:0]      hit_x,
	input logic [gcr_pkg::CELL_W-1:0]     hit_content,
	input logic                           hit_found
);
	import gcr_pkg::*;

	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_CAST) |=> busy)
		else $error("cast item did not raise busy");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_WRITE) |=> !busy)
		else $error("cell write raised busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_miss_defaults: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit_found) |-> (hit_distance == '1 && hit_x == '0 && hit_content == '0))
		else $error("miss result without default fields");

	a_hit_content: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit_found) |-> hit_content != '0)
		else $error("hit result with empty content");

endmodule

bind grid_ray_caster_top gcr_checker u_gcr_checker (.*);

// ===== tb/grid_ray_caster_top_test.sv =====
// ----------------------------------------------------------------------------
// grid_ray_caster_top_test: self-checking bench for the grid ray caster
// Writes tile maps cell by cell and casts rays; a built-in DDA predictor
// computes each expected hit, and the monitor compares every done result.
// ----------------------------------------------------------------------------
module grid_ray_caster_top_test;
	import gcr_pkg::*;

	typedef struct {
		logic                  cmd;
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
		logic [CELL_W-1:0]     val;
		logic [POS_W-1:0]      vx;
		logic [POS_W-1:0]      vy;
		logic [ANGLE_BITS-1:0] dir;
		logic [STRIP_W-1:0]    strip;
	} item_t;

	typedef struct {
		logic [STRIP_W-1:0]    strip;
		logic [DIST_W-1:0]     hdist;
		logic [POS_W-1:0]      hx;
		logic [POS_W-1:0]      hy;
		logic [CELL_W-1:0]     content;
		logic                  vert;
		logic                  found;
		logic [ANGLE_BITS-1:0] dir;
	} hit_t;

	typedef struct {
		bit             found;
		longint         x;
		longint         y;
		bit [CELL_W-1:0] content;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cmd = 1'b0;
	logic [ROW_W-1:0] cell_row = '0;
	logic [COL_W-1:0] cell_col = '0;
	logic [CELL_W-1:0] cell_value = '0;
	logic [POS_W-1:0] viewer_x = '0;
	logic [POS_W-1:0] viewer_y = '0;
	logic [ANGLE_BITS-1:0] ray_dir = '0;
	logic [STRIP_W-1:0] strip_number = '0;
	logic done;
	logic [STRIP_W-1:0] strip_out;
	logic [DIST_W-1:0] hit_distance;
	logic [POS_W-1:0] hit_x;
	logic [POS_W-1:0] hit_y;
	logic [CELL_W-1:0] hit_content;
	logic hit_on_vertical;
	logic hit_found;
	logic [ANGLE_BITS-1:0] dir_out;

	grid_ray_caster_top u_dut (.*);

	always #2 clk = ~clk;

	item_t pending_items[$];
	hit_t expected_hits[$];
	bit [CELL_W-1:0] map_model [CELLS];
	int errors = 0;
	bit stim_done = 0;
	bit quiet = 0;
	bit hold_for_drain = 0;

	localparam longint TILE_L = longint'(TILE_FX);
	localparam longint WID_L = longint'(MAP_COLS) * TILE_L;
	localparam longint HGT_L = longint'(MAP_ROWS) * TILE_L;
	localparam longint RSAT = longint'(1) << 33;

	function automatic longint fshift(longint v, int s);
		if (v >= 0) return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	function automatic void trig(input int unsigned ang, output longint s, output longint c);
		int unsigned ph;
		bit flip;
		longint x, y, z, nx, ny;
		ph = (ang << (16 - ANGLE_BITS)) & 16'hFFFF;
		flip = 0;
		x = CRD_X0;
		y = 0;
		if (ph >= 16384 && ph < 49152) begin
			flip = 1;
			ph = (ph - 32768) & 16'hFFFF;
		end
		z = (ph >= 32768) ? longint'(ph) - 65536 : longint'(ph);
		for (int i = 0; i < CRD_ITERS; i++) begin
			if (z >= 0) begin
				nx = x - fshift(y, i);
				ny = y + fshift(x, i);
				z -= crd_atan(4'(i));
			end else begin
				nx = x + fshift(y, i);
				ny = y - fshift(x, i);
				z += crd_atan(4'(i));
			end
			x = nx;
			y = ny;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint ratio(longint n, longint d);
		bit neg;
		longint an, ad, r;
		neg = (n < 0) != (d < 0);
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		if (an == 0) return 0;
		if (ad == 0) r = RSAT;
		else begin
			r = (an << 16) / ad;
			if (r > RSAT) r = RSAT;
		end
		return neg ? -r : r;
	endfunction

	function automatic longint qmul(longint a, longint q);
		bit neg;
		longint r;
		neg = (a < 0) != (q < 0);
		r = ((a < 0 ? -a : a) * (q < 0 ? -q : q)) >>> 16;
		return neg ? -r : r;
	endfunction

	function automatic bit [CELL_W-1:0] tile_at(longint x, longint y);
		if (x < 0 || x >= WID_L || y < 0 || y >= HGT_L) return '0;
		return map_model[(y / TILE_L) * MAP_COLS + (x / TILE_L)];
	endfunction

	function automatic probe_t walk(longint x, longint y, longint sx, longint sy,
			longint ox, longint oy);
		probe_t p;
		bit [CELL_W-1:0] v;
		p = '{0, 0, 0, 0};
		while (x >= 0 && x <= WID_L && y >= 0 && y <= HGT_L) begin
			v = tile_at(x + ox, y + oy);
			if (v != 0) begin
				p = '{1, x, y, v};
				break;
			end
			x += sx;
			y += sy;
		end
		return p;
	endfunction

	function automatic longint root(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint range_to(longint vx, longint vy, probe_t p);
		longint dx, dy;
		if (!p.found) return -1;
		dx = p.x - vx;
		dy = p.y - vy;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		if (dx >= (64'sd1 <<< 31) || dy >= (64'sd1 <<< 31)) return longint'(1) << 32;
		return root(dx * dx + dy * dy);
	endfunction

	function automatic longint clamp19(longint v);
		if (v < 0) return 0;
		return v > 524287 ? 524287 : v;
	endfunction

	// Updates the map model for writes; returns 1 with the expected hit for casts.
	function automatic bit cast_ray(item_t it, output hit_t e);
		int unsigned a;
		longint vx, vy, s, c, tq, cq, base, xs, ys, hd, vd;
		bit down, up, right, left, usev;
		probe_t h, v, pk;
		if (it.cmd == CMD_WRITE) begin
			map_model[it.row * MAP_COLS + it.col] = it.val;
			return 0;
		end
		vx = it.vx;
		vy = it.vy;
		a = it.dir;
		down = a > 0 && a < ANG_HALF;
		up = !down;
		right = a < ANG_QTR || a > ANG_3QTR;
		left = !right;
		trig(a, s, c);
		tq = ratio(s, c);
		cq = ratio(c, s);
		base = (vy / TILE_L) * TILE_L + (down ? TILE_L : 0);
		xs = qmul(TILE_L, cq);
		if (left && xs > 0) xs = -xs;
		if (right && xs < 0) xs = -xs;
		h = walk(vx + qmul(base - vy, cq), base, xs, up ? -TILE_L : TILE_L, 0,
			up ? -longint'(PIX_FX) : 0);
		base = (vx / TILE_L) * TILE_L + (right ? TILE_L : 0);
		ys = qmul(TILE_L, tq);
		if (up && ys > 0) ys = -ys;
		if (down && ys < 0) ys = -ys;
		v = walk(base, vy + qmul(base - vx, tq), left ? -TILE_L : TILE_L, ys,
			left ? -longint'(PIX_FX) : 0, 0);
		hd = range_to(vx, vy, h);
		vd = range_to(vx, vy, v);
		usev = vd >= 0 && (hd < 0 || vd < hd);
		pk = usev ? v : h;
		if (usev) hd = vd;
		e.strip = it.strip;
		e.hdist = (hd < 0 || hd > 1048575) ? DIST_W'(1048575) : DIST_W'(hd);
		e.hx = POS_W'(clamp19(pk.x));
		e.hy = POS_W'(clamp19(pk.y));
		e.content = pk.content;
		e.vert = usev;
		e.found = h.found || v.found;
		e.dir = it.dir;
		return 1;
	endfunction

	function automatic item_t cell_item(int r, int c, int v);
		item_t it;
		it = '{CMD_WRITE, ROW_W'(r), COL_W'(c), CELL_W'(v), POS_W'($urandom),
			POS_W'($urandom), ANGLE_BITS'($urandom), STRIP_W'($urandom)};
		return it;
	endfunction

	function automatic item_t ray_item(int x, int y, int d);
		item_t it;
		it = '{CMD_CAST, ROW_W'($urandom), COL_W'($urandom), CELL_W'($urandom),
			POS_W'(x), POS_W'(y), ANGLE_BITS'(d), STRIP_W'($urandom)};
		return it;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// Driver
	always @(posedge clk) begin
		hit_t e;
		if (arst_n) begin
			if (start && !busy) begin
				if (cast_ray(pending_items[0], e)) expected_hits.push_back(e);
				void'(pending_items.pop_front());
			end
			if (start && busy) begin
			end else if (pending_items.size() > 0 && !hold_for_drain &&
					(quiet || $urandom_range(99) >= 14)) begin
				start <= 1'b1;
				cmd <= pending_items[0].cmd;
				cell_row <= pending_items[0].row;
				cell_col <= pending_items[0].col;
				cell_value <= pending_items[0].val;
				viewer_x <= pending_items[0].vx;
				viewer_y <= pending_items[0].vy;
				ray_dir <= pending_items[0].dir;
				strip_number <= pending_items[0].strip;
			end else start <= 1'b0;
		end
	end

	// Monitor
	always @(posedge clk) begin
		hit_t e;
		if (arst_n && done) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("unexpected result, strip", strip_out, -1);
			end else begin
				e = expected_hits.pop_front();
				if (strip_out !== e.strip) report_mismatch("strip_out", strip_out, e.strip);
				if (hit_distance !== e.hdist)
					report_mismatch("hit_distance", hit_distance, e.hdist);
				if (hit_x !== e.hx) report_mismatch("hit_x", hit_x, e.hx);
				if (hit_y !== e.hy) report_mismatch("hit_y", hit_y, e.hy);
				if (hit_content !== e.content)
					report_mismatch("hit_content", hit_content, e.content);
				if (hit_on_vertical !== e.vert)
					report_mismatch("hit_on_vertical", hit_on_vertical, e.vert);
				if (hit_found !== e.found) report_mismatch("hit_found", hit_found, e.found);
				if (dir_out !== e.dir) report_mismatch("dir_out", dir_out, e.dir);
			end
		end
	end

	initial begin
		int n, x, y;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty map rays, axis angles, extreme positions
		pending_items.push_back(ray_item(100 << 8, 100 << 8, 0));
		pending_items.push_back(ray_item(0, 0, 1024));
		pending_items.push_back(ray_item(524287, 524287, 2048));
		pending_items.push_back(ray_item(524287, 0, 3072));
		// border cells at every fourth tile plus one interior cell
		for (int i = 0; i < 32; i += 31)
			for (int j = 0; j < 32; j += 4) begin
				pending_items.push_back(cell_item(i, j, 15));
				pending_items.push_back(cell_item(j, i, 1));
			end
		pending_items.push_back(cell_item(10, 10, 7));
		foreach (pending_items[k]) if (k < 4) pending_items[k].strip = (k == 0) ? 0 : 1023;
		pending_items.push_back(ray_item(1000 << 8, 1000 << 8, 512));
		pending_items.push_back(ray_item(640 << 8, 300 << 8, 1024));
		pending_items.push_back(ray_item(300 << 8, 640 << 8, 0));
		pending_items.push_back(ray_item(1024 << 8, 1024 << 8, 4095));
		pending_items.push_back(ray_item(2048 << 8, 2048 << 8, 2560));
		pending_items.push_back(ray_item(0, 1024 << 8, 2048));
		pending_items.push_back(ray_item(524287, 1024 << 8, 1));
		wait (pending_items.size() == 0);
		// hold off until all casts come back
		hold_for_drain = 1;
		wait (expected_hits.size() == 0);
		repeat (5) @(posedge clk);
		hold_for_drain = 0;
		n = 0;
		while (n < 750) begin
			if (n >= 300 && n < 420) quiet = 1;
			else quiet = 0;
			if ($urandom_range(99) < 35) begin
				if ($urandom_range(9) == 0)
					pending_items.push_back(cell_item($urandom, $urandom, 0));
				else
					pending_items.push_back(cell_item($urandom, $urandom, $urandom_range(15, 1)));
			end else begin
				if ($urandom_range(9) == 0) begin
					x = $urandom;
					y = $urandom;
				end else begin
					x = $urandom_range(WID_L - 1);
					y = $urandom_range(HGT_L - 1);
				end
				pending_items.push_back(ray_item(x, y, $urandom));
			end
			n++;
			if (pending_items.size() > 8) wait (pending_items.size() < 4);
		end
		wait (pending_items.size() == 0);
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		wait (expected_hits.size() == 0 && !start);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/gcr_pkg.sv
hdl/gcr_ram.sv
hdl/gcr_ctrl.sv
hdl/gcr_datapath.sv
hdl/grid_ray_caster_top.sv
hdl/gcr_checker.sv
tb/grid_ray_caster_top_test.sv
